### rtl/cdu_pkg.sv
// cdu_pkg: shared types and constants for the cosine distance unit
// used by the controller, the datapath, the top level and the testbench; no dependencies
package cdu_pkg;

    localparam int SCALE    = 1000;
    localparam int SCALE_W  = 10;
    localparam int DIST_W   = 11;
    localparam int DIST_MAX = 2000;
    localparam int T_W      = 12;   // signed search bound, -1000..1001
    localparam int TT_W     = 20;   // square of a search bound
    localparam int LO_INIT  = -SCALE;
    localparam int HI_INIT  = SCALE + 1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_CHECK,
        ST_GO,
        ST_RUN,
        ST_STEP
    } state_t;

    typedef enum logic [2:0] {
        OP_MAG,     // |dot| * 1000
        OP_SQ,      // (1000 |dot|)^2
        OP_PP,      // norm_a * norm_b
        OP_TT,      // t * t
        OP_RR       // t^2 * norm_a * norm_b
    } mul_op_t;

    typedef struct packed {
        logic    mul_start;
        mul_op_t op;
        logic    step_trivial;
        logic    res_load;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic trivial;
        logic search_done;
        logic out_full;
        logic mul_done;
    } status_t;

endpackage

### rtl/cdu_mul.sv
// cdu_mul: shift-and-add multiplier, one multiplier bit per cycle
// depends on nothing; used by cdu_datapath
module cdu_mul #(
    parameter int AW = 104,
    parameter int BW = 52
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic          done,
    output logic [AW-1:0] product
);

    logic          run_reg;
    logic [AW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [AW-1:0] acc_reg;

    assign done    = run_reg && (b_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (start) begin
            run_reg <= 1'b1;
        end else if (done) begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (run_reg && (b_reg != '0)) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

### rtl/cdu_datapath.sv
// cdu_datapath: accumulators, finishing registers, bisection bounds and result register
// depends on cdu_pkg and cdu_mul
module cdu_datapath
    import cdu_pkg::*;
#(
    parameter int COMP_WIDTH = 16,
    parameter int DOT_W      = 42,
    parameter int NORM_W     = 41
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_accept,
    input  logic                         in_last,
    input  logic signed [COMP_WIDTH-1:0] comp_a,
    input  logic signed [COMP_WIDTH-1:0] comp_b,
    input  cmd_t                         cmd,
    output status_t                      status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [DIST_W-1:0]            distance_milli,
    output logic                         zero_norm
);

    localparam int BW = DOT_W + SCALE_W;
    localparam int PW = 2 * BW;
    localparam int PP_W = 2 * NORM_W;

    logic [DOT_W-1:0]  dot_acc_reg;
    logic [NORM_W-1:0] norm_a_acc_reg, norm_b_acc_reg;
    logic [DOT_W-1:0]  dot_next;
    logic [NORM_W-1:0] norm_a_next, norm_b_next;

    logic signed [2*COMP_WIDTH-1:0] prod_ab, prod_aa, prod_bb;

    logic              dot_pos_reg;
    logic [DOT_W-1:0]  mag_reg;
    logic [NORM_W-1:0] na_reg, nb_reg;
    logic [PW-1:0]     l_reg;
    logic [PP_W-1:0]   p_reg;
    logic [TT_W-1:0]   tt_reg;
    mul_op_t           op_reg;

    logic signed [T_W-1:0] lo_reg, hi_reg, lo_next, hi_next, mid, span;
    logic [T_W-1:0]        mid_abs;
    logic signed [T_W:0]   dist_full;

    logic          out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic          zero_reg;

    logic [PW-1:0] mul_a, mul_p;
    logic [BW-1:0] mul_b;
    logic          mul_done, holds;

    assign prod_ab = comp_a * comp_b;
    assign prod_aa = comp_a * comp_a;
    assign prod_bb = comp_b * comp_b;

    assign dot_next    = dot_acc_reg + DOT_W'(prod_ab);
    assign norm_a_next = norm_a_acc_reg + NORM_W'($unsigned(prod_aa));
    assign norm_b_next = norm_b_acc_reg + NORM_W'($unsigned(prod_bb));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_acc_reg    <= '0;
            norm_a_acc_reg <= '0;
            norm_b_acc_reg <= '0;
        end else if (in_accept) begin
            if (in_last) begin
                dot_acc_reg    <= '0;
                norm_a_acc_reg <= '0;
                norm_b_acc_reg <= '0;
            end else begin
                dot_acc_reg    <= dot_next;
                norm_a_acc_reg <= norm_a_next;
                norm_b_acc_reg <= norm_b_next;
            end
        end
    end

    // snapshot on the last transfer of a vector pair
    always_ff @(posedge aclk) begin
        if (in_accept && in_last) begin
            dot_pos_reg <= !dot_next[DOT_W-1] && (dot_next != '0);
            mag_reg     <= dot_next[DOT_W-1] ? (DOT_W'(0) - dot_next) : dot_next;
            na_reg      <= norm_a_next;
            nb_reg      <= norm_b_next;
        end
    end

    assign span    = hi_reg - lo_reg;
    assign mid     = lo_reg + (span >>> 1);
    assign mid_abs = mid[T_W-1] ? T_W'(-mid) : T_W'(mid);

    always_comb begin
        case (cmd.op)
            OP_MAG: begin
                mul_a = PW'(mag_reg);
                mul_b = BW'(SCALE);
            end
            OP_SQ: begin
                mul_a = l_reg;
                mul_b = l_reg[BW-1:0];
            end
            OP_PP: begin
                mul_a = PW'(na_reg);
                mul_b = BW'(nb_reg);
            end
            OP_TT: begin
                mul_a = PW'(mid_abs);
                mul_b = BW'(mid_abs);
            end
            OP_RR: begin
                mul_a = PW'(p_reg);
                mul_b = BW'(tt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    cdu_mul #(.AW(PW), .BW(BW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            op_reg <= cmd.op;
        end
        if (mul_done) begin
            case (op_reg)
                OP_MAG, OP_SQ: l_reg  <= mul_p;
                OP_PP:         p_reg  <= mul_p[PP_W-1:0];
                OP_TT:         tt_reg <= mul_p[TT_W-1:0];
                default: ;
            endcase
        end
    end

    // positive dot: 1000 dot <= t sqrt(P) when L <= t^2 P; negative: when L >= t^2 P
    assign holds = dot_pos_reg ? (l_reg <= mul_p) : (l_reg >= mul_p);

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (in_accept && in_last) begin
            lo_next = T_W'(LO_INIT);
            hi_next = T_W'(HI_INIT);
        end else if (cmd.step_trivial) begin
            if (!dot_pos_reg) begin
                hi_next = mid;
            end else begin
                lo_next = mid + T_W'(1);
            end
        end else if (mul_done && (op_reg == OP_RR)) begin
            if (holds) begin
                hi_next = mid;
            end else begin
                lo_next = mid + T_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign dist_full = (T_W+1)'(SCALE) - (T_W+1)'(lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            zero_reg <= status.zero;
            if (status.zero || dist_full[T_W]) begin
                dist_reg <= '0;
            end else begin
                dist_reg <= DIST_W'(dist_full);
            end
        end
    end

    assign status.zero        = (na_reg == '0) || (nb_reg == '0);
    assign status.trivial     = dot_pos_reg ? (mid <= 0) : (mid >= 0);
    assign status.search_done = (lo_reg >= hi_reg);
    assign status.out_full    = out_valid_reg;
    assign status.mul_done    = mul_done;

    assign out_valid      = out_valid_reg;
    assign distance_milli = dist_reg;
    assign zero_norm      = zero_reg;

endmodule

### rtl/cdu_ctrl.sv
// cdu_ctrl: sequencer for accumulation, the multiply chain and the bisection
// depends on cdu_pkg
module cdu_ctrl
    import cdu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_accept,
    input  logic    in_last,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            op_reg    <= OP_MAG;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        in_ready         = 1'b0;
        cmd.mul_start    = 1'b0;
        cmd.op           = op_reg;
        cmd.step_trivial = 1'b0;
        cmd.res_load     = 1'b0;
        case (state_reg)
            ST_ACC: begin
                in_ready = 1'b1;
                if (in_accept && in_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.zero) begin
                    if (!status.out_full) begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_ACC;
                    end
                end else begin
                    op_next    = OP_MAG;
                    state_next = ST_GO;
                end
            end
            ST_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                if (status.mul_done) begin
                    case (op_reg)
                        OP_MAG: begin
                            op_next    = OP_SQ;
                            state_next = ST_GO;
                        end
                        OP_SQ: begin
                            op_next    = OP_PP;
                            state_next = ST_GO;
                        end
                        OP_TT: begin
                            op_next    = OP_RR;
                            state_next = ST_GO;
                        end
                        default: state_next = ST_STEP;
                    endcase
                end
            end
            ST_STEP: begin
                if (status.search_done) begin
                    if (!status.out_full) begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_ACC;
                    end
                end else if (status.trivial) begin
                    cmd.step_trivial = 1'b1;
                end else begin
                    op_next    = OP_TT;
                    state_next = ST_GO;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

endmodule

### rtl/cosine_distance_unit_top.sv
// Cosine distance unit: one component pair per transfer on the slave side; the transfer with
// tlast set closes the pair of vectors, and one result follows on the master side: the floor
// of 1000 * (1 - dot / sqrt(|a|^2 |b|^2)) clamped to 0..2000, with tuser set (and distance 0)
// when either norm is zero. Components are accumulated at one per cycle. After tlast the
// block stops taking transfers while a single shift-and-add multiplier, one bit per cycle,
// works out the result: first the three fixed products, then an 11-step bisection in which
// each step that the signs do not settle runs two more products. A finished result waits
// in an output register while the next vector pair streams in. Accumulators wrap beyond
// MAX_DIM components.
// depends on cdu_pkg, cdu_ctrl, cdu_datapath
module cosine_distance_unit_top
    import cdu_pkg::*;
#(
    parameter int MAX_DIM    = 1024,
    parameter int COMP_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((2*COMP_WIDTH+7)/8)*8-1:0] s_tdata,  // comp_a, comp_b, zero fill
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // distance_milli, zero fill
    output logic [0:0]                        m_tuser   // zero_norm
);

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int DOT_W  = 2 * COMP_WIDTH + DIM_W;
    localparam int NORM_W = 2 * COMP_WIDTH - 1 + DIM_W;

    cmd_t    cmd;
    status_t status;
    logic    in_accept;
    logic [DIST_W-1:0] distance_milli;
    logic    zero_norm;

    assign in_accept = s_tvalid && s_tready;

    cdu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_last   (s_tlast),
        .status    (status),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    cdu_datapath #(
        .COMP_WIDTH (COMP_WIDTH),
        .DOT_W      (DOT_W),
        .NORM_W     (NORM_W)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (in_accept),
        .in_last        (s_tlast),
        .comp_a         ($signed(s_tdata[COMP_WIDTH-1:0])),
        .comp_b         ($signed(s_tdata[2*COMP_WIDTH-1:COMP_WIDTH])),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .distance_milli (distance_milli),
        .zero_norm      (zero_norm)
    );

    assign m_tdata    = 16'(distance_milli);
    assign m_tuser[0] = zero_norm;

endmodule

### rtl/cdu_checker.sv
// cdu_checker: port-level checks on the cosine distance unit, bound to the top level
// depends on cosine_distance_unit_top
module cdu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:0] <= 11'd2000) && (m_tdata[15:11] == 5'd0))
        else $error("distance out of range");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[10:0] == 11'd0))
        else $error("zero norm with non-zero distance");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind cosine_distance_unit_top cdu_checker u_cdu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### test/tb_cosine_distance_unit_top.sv
// Self-checking testbench for cosine_distance_unit_top: streams component pairs and predicts
// each distance with an exact integer bisection, then checks every result transfer
// depends on cdu_pkg and cosine_distance_unit_top
`timescale 1ns / 1ps

module tb_cosine_distance_unit_top;
    import cdu_pkg::*;

    localparam int NORM_W = 41;
    localparam int DOT_W  = 42;

    typedef struct {
        logic signed [15:0] comp_a;
        logic signed [15:0] comp_b;
        logic               last;
    } pair_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              zero_norm;
    } dist_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    pair_t pending_pairs[$];
    dist_t expected_dists[$];
    pair_t on_bus;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int err_count = 0;
    int vectors_sent = 0;
    int results_seen = 0;
    int zero_results = 0;

    logic [DOT_W-1:0]  dot_sum = '0;
    logic [NORM_W-1:0] norm_a_sum = '0;
    logic [NORM_W-1:0] norm_b_sum = '0;

    cosine_distance_unit_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // true when 1000*dot <= t*sqrt(na*nb), compared through squares
    function automatic bit dist_bound_holds(longint dot, int t, logic [NORM_W-1:0] na,
                                            logic [NORM_W-1:0] nb);
        logic [127:0] mag;
        logic [127:0] lhs;
        logic [127:0] rhs;
        if (dot <= 0 && t >= 0) return 1'b1;
        if (dot > 0 && t <= 0) return 1'b0;
        mag = 128'((dot < 0) ? -dot : dot) * 128'(SCALE);
        lhs = mag * mag;
        rhs = 128'(na) * 128'(t * t) * 128'(nb);
        return (dot > 0) ? (lhs <= rhs) : (lhs >= rhs);
    endfunction

    // accumulate one pair; on the closing pair queue the expected distance
    task automatic accumulate_pair(pair_t p);
        logic signed [DOT_W-1:0] dot_signed;
        longint dot;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
        int lo;
        int hi;
        int mid;
        int milli;
        dist_t d;
        dot_sum    = dot_sum + DOT_W'(longint'(p.comp_a) * longint'(p.comp_b));
        norm_a_sum = norm_a_sum + NORM_W'(longint'(p.comp_a) * longint'(p.comp_a));
        norm_b_sum = norm_b_sum + NORM_W'(longint'(p.comp_b) * longint'(p.comp_b));
        if (!p.last) return;
        dot_signed = dot_sum;
        dot = dot_signed;
        na = norm_a_sum;
        nb = norm_b_sum;
        dot_sum = '0;
        norm_a_sum = '0;
        norm_b_sum = '0;
        if (na == 0 || nb == 0) begin
            d.distance = '0;
            d.zero_norm = 1'b1;
        end else begin
            lo = LO_INIT;
            hi = HI_INIT;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (dist_bound_holds(dot, mid, na, nb)) hi = mid;
                else lo = mid + 1;
            end
            milli = SCALE - lo;
            if (milli < 0) milli = 0;
            if (milli > DIST_MAX) milli = DIST_MAX;
            d.distance = DIST_W'(milli);
            d.zero_norm = 1'b0;
        end
        expected_dists = {expected_dists, d};
    endtask

    // sender: valid held until the transfer happens
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) accumulate_pair(on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.comp_b, on_bus.comp_a};
                    s_tlast <= on_bus.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with random stalls and an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        dist_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_dists.size() == 0) begin
                $error("unexpected result transfer: distance %0d zero_norm %0d",
                       m_tdata[DIST_W-1:0], m_tuser[0]);
                err_count++;
            end else begin
                want = expected_dists.pop_front();
                if (want.zero_norm) zero_results++;
                if (m_tdata[DIST_W-1:0] !== want.distance) begin
                    $error("distance_milli: expected %0d, got %0d", want.distance,
                           m_tdata[DIST_W-1:0]);
                    err_count++;
                end
                if (m_tuser[0] !== want.zero_norm) begin
                    $error("zero_norm: expected %0d, got %0d", want.zero_norm, m_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    task automatic add_pair(int a, int b, bit last);
        pair_t p;
        p.comp_a = 16'(a);
        p.comp_b = 16'(b);
        p.last = last;
        pending_pairs = {pending_pairs, p};
        if (last) vectors_sent++;
    endtask

    // one vector pair with random content; b is often tied to a to reach the range ends
    task automatic add_random_vector(int len);
        int style;
        int a;
        int b;
        style = $urandom_range(5);
        for (int i = 0; i < len; i++) begin
            a = $signed(16'($urandom));
            case (style)
                0: b = a;
                1: b = -a;
                2: b = a + $signed(8'($urandom)) / 4;
                3: b = $urandom_range(1) ? 0 : $signed(16'($urandom));
                4: begin
                    a = $signed(16'($urandom_range(1) ? 16'h8000 : 16'h7fff));
                    b = $signed(16'($urandom));
                end
                default: b = $signed(16'($urandom));
            endcase
            if (b > 32767) b = 32767;
            if (b < -32768) b = -32768;
            add_pair(a, b, i == len - 1);
        end
    endtask

    task automatic drain;
        while (pending_pairs.size() > 0 || s_tvalid || expected_dists.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero norms, identical, opposite, orthogonal, extremes
        add_pair(0, 0, 1);
        add_pair(0, 4096, 0);
        add_pair(0, -1, 1);
        add_pair(5, 0, 1);
        add_pair(-32768, -32768, 1);
        add_pair(32767, -32768, 1);
        add_pair(32767, 32767, 0);
        add_pair(-32768, -32768, 1);
        add_pair(4096, 0, 0);
        add_pair(0, 4096, 1);
        add_pair(1, 1, 0);
        add_pair(1, -1, 1);
        add_pair(4096, 4096, 0);
        add_pair(4096, 4095, 0);
        add_pair(-1, 0, 1);
        add_pair(12345, -23456, 1);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                3: begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (phase == 4) hold_cycles <= 3000;
            for (int n = 0; n < 150; ) begin
                int len;
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 64)
                                                : $urandom_range(1, 8);
                add_random_vector(len);
                n += len;
            end
            drain();
        end

        repeat (600) @(posedge aclk);
        $display("covered %0d vector pairs, %0d results checked (%0d with zero norm)",
                 vectors_sent, results_seen, zero_results);
        $display("directed extremes, zero norms, idle/stall phases and a long hold-off");
        if (err_count == 0 && expected_dists.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("timeout with %0d results outstanding", expected_dists.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
